// ===== hdl/rcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rcm_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int ID_W    = 29;
    localparam int CNT_W   = 8;
    localparam int BITS_W  = 4;
    localparam int SCORE_W = 8;

    localparam logic [SCORE_W-1:0] FAIL_LIMIT_RESET = 8'd5;
    localparam logic [SCORE_W-1:0] SCORE_MAX        = 8'd255;
    localparam logic [BITS_W-1:0]  CNT_BITS_MAX     = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    // One tracked identifier
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [CNT_W-1:0]   count;
        logic [SCORE_W-1:0] score;
    } t_entry;

    // Frame under test, broadcast to every cell
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [CNT_W-1:0]   cnt;
        logic [BITS_W-1:0]  bits;
        logic [SCORE_W-1:0] limit;
    } t_query;

    // Verdict a cell proposes for its own entry
    typedef struct packed {
        logic               ok;
        logic               seqerr;
        logic [SCORE_W-1:0] score;
    } t_prop;

    // Per-cycle commands from the sequencer to the cells
    typedef struct packed {
        logic lookup;
        logic update;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hdl/rcm_frame_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rcm_frame_if;
    logic                        valid;
    logic                        ready;
    logic [rcm_pkg::ID_W-1:0]    frame_id;
    logic [rcm_pkg::CNT_W-1:0]   counter_value;
    logic [rcm_pkg::BITS_W-1:0]  counter_bits;

    modport source (output valid, frame_id, counter_value, counter_bits, input ready);
    modport sink   (input valid, frame_id, counter_value, counter_bits, output ready);
endinterface

`default_nettype wire

// ===== hdl/rcm_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rcm_result_if;
    logic                        valid;
    logic                        ready;
    logic                        frame_ok;
    logic                        first_seen;
    logic                        sequence_error;
    logic                        table_full;
    logic [rcm_pkg::SCORE_W-1:0] fail_score;

    modport source (output valid, frame_ok, first_seen, sequence_error, table_full,
                    fail_score, input ready);
    modport sink   (input valid, frame_ok, first_seen, sequence_error, table_full,
                    fail_score, output ready);
endinterface

`default_nettype wire

// ===== hdl/rcm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One table slot: holds an entry, checks the broadcast frame against it and
// takes its upstream neighbor's entry when a new identifier is pushed in.
module rcm_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rcm_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_occupied,
    input  wire rcm_pkg::t_query    i_query,
    input  wire rcm_pkg::t_entry    i_prev,
    output rcm_pkg::t_entry         o_entry,
    output logic                    o_hit,
    output rcm_pkg::t_prop          o_prop
);

    rcm_pkg::t_entry r_entry;
    logic            r_hit;
    rcm_pkg::t_prop  r_prop;

    logic [rcm_pkg::BITS_W-1:0]  w_bits;
    logic [rcm_pkg::CNT_W:0]     w_mask_wide;
    logic [rcm_pkg::CNT_W-1:0]   w_expect;
    logic                        w_match;
    logic [rcm_pkg::SCORE_W-1:0] w_score;
    rcm_pkg::t_prop              n_prop;

    // Expected counter and score update for this slot
    always_comb begin
        w_bits      = (i_query.bits > rcm_pkg::CNT_BITS_MAX) ? rcm_pkg::CNT_BITS_MAX
                                                             : i_query.bits;
        w_mask_wide = (9'd1 << w_bits) - 9'd1;
        w_expect    = (r_entry.count + 8'd1) & w_mask_wide[rcm_pkg::CNT_W-1:0];
        w_match     = (w_expect == i_query.cnt);
        if (!w_match) begin
            w_score = (r_entry.score != rcm_pkg::SCORE_MAX) ? r_entry.score + 8'd1
                                                            : r_entry.score;
        end else begin
            w_score = (r_entry.score != '0) ? r_entry.score - 8'd1 : r_entry.score;
        end
        n_prop.seqerr = !w_match;
        n_prop.score  = w_score;
        n_prop.ok     = w_match || (w_score < i_query.limit);
    end

    // Hit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.lookup) begin
            r_hit <= i_occupied && (r_entry.id == i_query.id);
        end
    end

    // Proposal, held for the update cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.lookup) begin
            r_prop <= n_prop;
        end
    end

    // Entry: shift in from the neighbor, or write back on a hit
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_prev;
        end else if (i_ctl.update && r_hit) begin
            r_entry.count <= i_query.cnt;
            r_entry.score <= r_prop.score;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;
    assign o_prop  = r_prop;

endmodule

`default_nettype wire

// ===== hdl/rolling_counter_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Alive-counter monitor for CAN frames. Each frame beat is checked against a
// table of up to rcm_pkg::TABLE_DEPTH identifiers held in a row of cells, one
// identifier per cell; a new identifier, if the table has room, is pushed in
// at the head of the row and every occupied cell hands its entry to the next.
// After a frame is accepted, a lookup state lets all cells compare and score
// in parallel, and an update state merges the matching cell's verdict, writes
// back or inserts, and registers the result. The input is ready again once
// the result is registered, so no new frame is taken during lookup or update;
// a result waiting on the output does not block the next frame's acceptance,
// only its update step. No table clearing is needed after reset.
module rolling_counter_monitor (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [rcm_pkg::SCORE_W-1:0] i_cfg_data,
    rcm_frame_if.sink                        i_frame,
    rcm_result_if.source                     o_result
);

    localparam int DEPTH = rcm_pkg::TABLE_DEPTH;

    rcm_pkg::t_state r_state;
    rcm_pkg::t_state n_state;

    logic [rcm_pkg::SCORE_W-1:0]  r_fail_limit;
    logic [rcm_pkg::USED_W-1:0]   r_used;
    logic [rcm_pkg::ID_W-1:0]     r_id;
    logic [rcm_pkg::CNT_W-1:0]    r_cnt;
    logic [rcm_pkg::BITS_W-1:0]   r_bits;

    logic                         r_out_valid;
    logic                         r_ok;
    logic                         r_first;
    logic                         r_seqerr;
    logic                         r_full;
    logic [rcm_pkg::SCORE_W-1:0]  r_score;

    rcm_pkg::t_query    w_query;
    rcm_pkg::t_cell_ctl w_ctl;
    rcm_pkg::t_entry    w_new_entry;
    rcm_pkg::t_entry    w_entry [DEPTH];
    rcm_pkg::t_entry    w_prev  [DEPTH];
    rcm_pkg::t_prop     w_prop  [DEPTH];
    logic [DEPTH-1:0]   w_hit;
    logic [DEPTH-1:0]   w_occupied;
    rcm_pkg::t_prop     w_sel;

    logic w_accept;
    logic w_fire;
    logic w_any_hit;
    logic w_table_full;
    logic w_out_take;

    assign w_accept     = i_frame.valid && i_frame.ready;
    assign w_out_take   = r_out_valid && o_result.ready;
    assign w_any_hit    = |w_hit;
    assign w_table_full = (r_used == rcm_pkg::USED_W'(DEPTH));
    assign w_fire       = (r_state == rcm_pkg::ST_UPDATE) && (!r_out_valid || o_result.ready);

    assign i_frame.ready = (r_state == rcm_pkg::ST_IDLE);

    // Fail limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_limit <= rcm_pkg::FAIL_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_fail_limit <= i_cfg_data;
        end
    end

    // Frame capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id   <= i_frame.frame_id;
            r_cnt  <= i_frame.counter_value;
            r_bits <= i_frame.counter_bits;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_ctl.lookup = 1'b0;
        w_ctl.update = 1'b0;
        w_ctl.shift  = 1'b0;
        case (r_state)
            rcm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = rcm_pkg::ST_LOOKUP;
                end
            end
            rcm_pkg::ST_LOOKUP: begin
                w_ctl.lookup = 1'b1;
                n_state      = rcm_pkg::ST_UPDATE;
            end
            rcm_pkg::ST_UPDATE: begin
                if (w_fire) begin
                    w_ctl.update = w_any_hit;
                    w_ctl.shift  = !w_any_hit && !w_table_full;
                    n_state      = rcm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rcm_pkg::ST_IDLE;
            end
        endcase
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (w_ctl.shift) begin
            r_used <= r_used + 1'b1;
        end
    end

    assign w_query.id    = r_id;
    assign w_query.cnt   = r_cnt;
    assign w_query.bits  = r_bits;
    assign w_query.limit = r_fail_limit;

    assign w_new_entry.id    = r_id;
    assign w_new_entry.count = r_cnt;
    assign w_new_entry.score = '0;

    // Row of cells; the head takes the new entry
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_prev[k] = w_new_entry;
        end else begin : g_link
            assign w_prev[k] = w_entry[k-1];
        end
        assign w_occupied[k] = (r_used > rcm_pkg::USED_W'(k));

        rcm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_occupied (w_occupied[k]),
            .i_query    (w_query),
            .i_prev     (w_prev[k]),
            .o_entry    (w_entry[k]),
            .o_hit      (w_hit[k]),
            .o_prop     (w_prop[k])
        );
    end

    // Identifiers are unique, so at most one cell hits: plain AND-OR merge
    always_comb begin
        w_sel = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_hit[k]) begin
                w_sel = rcm_pkg::t_prop'(w_sel | w_prop[k]);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_ok     <= w_any_hit ? w_sel.ok : 1'b1;
            r_first  <= !w_any_hit && !w_table_full;
            r_seqerr <= w_any_hit && w_sel.seqerr;
            r_full   <= !w_any_hit && w_table_full;
            r_score  <= w_any_hit ? w_sel.score : '0;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.frame_ok       = r_ok;
    assign o_result.first_seen     = r_first;
    assign o_result.sequence_error = r_seqerr;
    assign o_result.table_full     = r_full;
    assign o_result.fail_score     = r_score;

    // Fill count never passes the table depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= rcm_pkg::USED_W'(DEPTH))
        else $error("fill count beyond table depth");

    // Unique identifiers: never more than one hitting cell
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcm_pkg::ST_UPDATE) |-> $onehot0(w_hit))
        else $error("more than one cell hit");

    // The update step always registers a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("result not registered after update");

    // An insertion grows the table by exactly one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.shift |=> (r_used == $past(r_used) + 1'b1))
        else $error("fill count did not advance on insert");

    // No update without a preceding lookup
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == rcm_pkg::ST_UPDATE) |-> $past(r_state) == rcm_pkg::ST_LOOKUP)
        else $error("update entered without lookup");

endmodule

`default_nettype wire
